### src/bfdh_pkg.sv
package bfdh_pkg;

  // sizing defaults
  localparam int FILTER_WORDS_DEF = 16384;
  localparam int MAX_PROBES_DEF   = 20;

  // configuration
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int BIT_COUNT_W   = 21;
  localparam int PROBE_COUNT_W = 5;
  localparam logic [BIT_COUNT_W-1:0]   BIT_COUNT_RST   = 21'd1048576;
  localparam logic [PROBE_COUNT_W-1:0] PROBE_COUNT_RST = 5'd7;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROBE_COUNT = 2'd1;

  // hash constants
  localparam logic [63:0] GOLD_A = 64'h9E3779B185EBCA87;
  localparam logic [63:0] GOLD_B = 64'hC2B2AE3D27D4EB4F;
  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  // remainder unit: bits retired per cycle and steps per 64-bit dividend
  localparam int DIV_BITS  = 4;
  localparam int DIV_STEPS = 64 / DIV_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // multiplier sequence: three partial products per hash
  localparam int MUL_STEPS = 6;
  localparam int MUL_SEL_W = 3;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [63:0] volume_key;
    logic [63:0] file_key_low;
    logic [63:0] file_key_high;
  } req_t;

  typedef struct packed {
    logic        maybe_present;
    logic [31:0] inserted_count;
  } res_t;

  // controller to datapath
  typedef struct packed {
    logic                 load;
    logic                 mix1;
    logic                 mix2;
    logic                 mul_en;
    logic [MUL_SEL_W-1:0] mul_sel;
    logic                 probe_load;
    logic                 probe_first;
    logic                 mod_step;
    logic                 check;
    logic                 clr_wr;
    logic                 fire;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    cmd_t cmd;
    logic bit_set;
  } sts_t;

endpackage

### src/bfdh_ram.sv
module bfdh_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16384,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/bfdh_datapath.sv
module bfdh_datapath #(
  parameter int FILTER_WORDS = bfdh_pkg::FILTER_WORDS_DEF,
  parameter int AW  = (FILTER_WORDS > 1) ? $clog2(FILTER_WORDS) : 1,
  parameter int NBW = $clog2(FILTER_WORDS * 64 + 1)
) (
  input  logic            clk,
  input  logic            rst,
  input  bfdh_pkg::ctl_t  ctl,
  input  logic [AW-1:0]   clr_addr,
  input  bfdh_pkg::req_t  req,
  input  logic [NBW-1:0]  nb,
  output bfdh_pkg::sts_t  sts,
  output bfdh_pkg::res_t  res
);

  bfdh_pkg::cmd_t cmd;
  logic [63:0] vkey, lkey, hkey;
  logic [63:0] mix_a, mix_b;
  logic [63:0] h1, h2;
  logic [63:0] pos, pos_next;
  logic [63:0] shreg;
  logic [NBW-1:0] rem, rem_next;
  logic [63:0] shreg_next;
  logic        present;
  logic [31:0] count, count_next;
  logic [31:0] mul_a, mul_c;
  logic [63:0] prod;
  logic [31:0] word_full;
  logic [AW-1:0] word;
  logic [5:0]  bit_sel;
  logic [63:0] rd_data;
  logic        we;
  logic [AW-1:0] waddr;
  logic [63:0] wdata;

  // one restoring step of the remainder
  function automatic logic [NBW-1:0] rem_step(input logic [NBW-1:0] r, input logic b,
                                              input logic [NBW-1:0] d);
    logic [NBW:0] t;
    t = {r, b};
    if (t >= {1'b0, d}) begin
      t = t - {1'b0, d};
    end
    return t[NBW-1:0];
  endfunction

  // select multiplier operands
  always_comb begin
    case (ctl.mul_sel)
      3'd0: begin mul_a = mix_a[31:0];  mul_c = bfdh_pkg::GOLD_A[31:0];  end
      3'd1: begin mul_a = mix_a[31:0];  mul_c = bfdh_pkg::GOLD_A[63:32]; end
      3'd2: begin mul_a = mix_a[63:32]; mul_c = bfdh_pkg::GOLD_A[31:0];  end
      3'd3: begin mul_a = mix_b[31:0];  mul_c = bfdh_pkg::GOLD_B[31:0];  end
      3'd4: begin mul_a = mix_b[31:0];  mul_c = bfdh_pkg::GOLD_B[63:32]; end
      default: begin mul_a = mix_b[63:32]; mul_c = bfdh_pkg::GOLD_B[31:0]; end
    endcase
    prod = {32'd0, mul_a} * {32'd0, mul_c};
  end

  // next probe position and remainder steps
  always_comb begin
    pos_next = ctl.probe_first ? h1 : pos + h2;
    rem_next = rem;
    shreg_next = shreg;
    for (int j = 0; j < bfdh_pkg::DIV_BITS; j++) begin
      rem_next   = rem_step(rem_next, shreg_next[63], nb);
      shreg_next = {shreg_next[62:0], 1'b0};
    end
  end

  // word and bit from the remainder, word held inside the store
  always_comb begin
    word_full = 32'(rem >> 6);
    if (word_full >= 32'(FILTER_WORDS)) begin
      word = AW'(FILTER_WORDS - 1);
    end else begin
      word = word_full[AW-1:0];
    end
    bit_sel = rem[5:0];
  end

  // store write: sweep zeroes, add sets the probed bit
  always_comb begin
    if (ctl.clr_wr) begin
      we    = 1'b1;
      waddr = clr_addr;
      wdata = '0;
    end else begin
      we    = ctl.check && (cmd == bfdh_pkg::CMD_ADD);
      waddr = word;
      wdata = rd_data | (64'd1 << bit_sel);
    end
  end

  bfdh_ram #(
    .WIDTH (64),
    .DEPTH (FILTER_WORDS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (word),
    .rdata (rd_data)
  );

  always_comb begin
    count_next = count;
    if (cmd == bfdh_pkg::CMD_ADD && count != bfdh_pkg::COUNT_MAX) begin
      count_next = count + 32'd1;
    end
  end

  assign sts.cmd     = cmd;
  assign sts.bit_set = rd_data[bit_sel];

  // key capture, hashing and probe registers
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd     <= req.cmd;
      vkey    <= req.volume_key;
      lkey    <= req.file_key_low;
      hkey    <= req.file_key_high;
      present <= (req.cmd == bfdh_pkg::CMD_ADD) || (req.cmd == bfdh_pkg::CMD_QUERY);
    end
    if (ctl.mix1) begin
      mix_a <= (vkey << 5) - vkey + lkey;
      mix_b <= (hkey << 5) + (hkey << 2) + hkey + lkey;
    end
    if (ctl.mix2) begin
      mix_a <= (mix_a << 5) - mix_a + hkey;
      mix_b <= (mix_b << 5) + (mix_b << 2) + mix_b + vkey;
    end
    if (ctl.mul_en) begin
      case (ctl.mul_sel)
        3'd0: h1 <= prod;
        3'd1, 3'd2: h1[63:32] <= h1[63:32] + prod[31:0];
        3'd3: h2 <= prod;
        default: h2[63:32] <= h2[63:32] + prod[31:0];
      endcase
    end
    if (ctl.probe_load) begin
      pos   <= pos_next;
      shreg <= pos_next;
      rem   <= '0;
    end else if (ctl.mod_step) begin
      shreg <= shreg_next;
      rem   <= rem_next;
    end
    if (ctl.check && cmd == bfdh_pkg::CMD_QUERY && !sts.bit_set) begin
      present <= 1'b0;
    end
    if (ctl.fire) begin
      res.maybe_present  <= present;
      res.inserted_count <= count_next;
    end
  end

  // key counter
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.load && req.cmd == bfdh_pkg::CMD_CLEAR) begin
      count <= '0;
    end else if (ctl.fire) begin
      count <= count_next;
    end
  end

endmodule

### src/bfdh_ctrl.sv
module bfdh_ctrl #(
  parameter int FILTER_WORDS = bfdh_pkg::FILTER_WORDS_DEF,
  parameter int MAX_PROBES   = bfdh_pkg::MAX_PROBES_DEF,
  parameter int AW = (FILTER_WORDS > 1) ? $clog2(FILTER_WORDS) : 1,
  parameter int PW = $clog2(MAX_PROBES + 1)
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  bfdh_pkg::cmd_t start_cmd,
  input  logic [PW-1:0]  np,
  input  bfdh_pkg::sts_t sts,
  output bfdh_pkg::ctl_t ctl,
  output logic [AW-1:0]  clr_addr,
  output logic           busy,
  output logic           res_valid
);

  typedef enum logic [3:0] {
    S_IDLE, S_SWEEP, S_MIX1, S_MIX2, S_MUL, S_PREP, S_MOD, S_READ, S_CHECK, S_FIN
  } state_t;

  state_t state;
  logic   sweep_cmd;
  logic [bfdh_pkg::MUL_SEL_W-1:0] msel;
  logic [bfdh_pkg::DIV_CNT_W-1:0] dstep;
  logic [PW-1:0] pidx;

  // decode commands from state
  always_comb begin
    ctl = '0;
    ctl.load        = (state == S_IDLE) && start;
    ctl.mix1        = (state == S_MIX1);
    ctl.mix2        = (state == S_MIX2);
    ctl.mul_en      = (state == S_MUL);
    ctl.mul_sel     = msel;
    ctl.probe_load  = (state == S_PREP);
    ctl.probe_first = (pidx == '0);
    ctl.mod_step    = (state == S_MOD);
    ctl.check       = (state == S_CHECK);
    ctl.clr_wr      = (state == S_SWEEP);
    ctl.fire        = (state == S_FIN);
  end

  assign busy = (state != S_IDLE);

  // sequence: sweep after reset, then hash, probe, report
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_SWEEP;
      sweep_cmd <= 1'b0;
      clr_addr  <= '0;
      msel      <= '0;
      dstep     <= '0;
      pidx      <= '0;
      res_valid <= 1'b0;
    end else begin
      res_valid <= (state == S_FIN);
      unique case (state)
        S_IDLE: begin
          if (start) begin
            pidx <= '0;
            msel <= '0;
            clr_addr <= '0;
            if (start_cmd == bfdh_pkg::CMD_ADD || start_cmd == bfdh_pkg::CMD_QUERY) begin
              state <= S_MIX1;
            end else if (start_cmd == bfdh_pkg::CMD_CLEAR) begin
              sweep_cmd <= 1'b1;
              state     <= S_SWEEP;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_SWEEP: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(FILTER_WORDS - 1)) begin
            state     <= sweep_cmd ? S_FIN : S_IDLE;
            sweep_cmd <= 1'b0;
          end
        end
        S_MIX1: state <= S_MIX2;
        S_MIX2: state <= S_MUL;
        S_MUL: begin
          msel <= msel + 1'b1;
          if (msel == bfdh_pkg::MUL_SEL_W'(bfdh_pkg::MUL_STEPS - 1)) begin
            state <= S_PREP;
          end
        end
        S_PREP: begin
          dstep <= '0;
          state <= S_MOD;
        end
        S_MOD: begin
          dstep <= dstep + 1'b1;
          if (dstep == bfdh_pkg::DIV_CNT_W'(bfdh_pkg::DIV_STEPS - 1)) begin
            state <= S_READ;
          end
        end
        S_READ: state <= S_CHECK;
        S_CHECK: begin
          pidx <= pidx + 1'b1;
          if ((sts.cmd == bfdh_pkg::CMD_QUERY && !sts.bit_set) || pidx == np - 1'b1) begin
            state <= S_FIN;
          end else begin
            state <= S_PREP;
          end
        end
        S_FIN: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### src/bloom_filter_double_hash_unit.sv
// Channel   Signals                            Direction  Handshake
// request   start, busy, req                   in / out   start high while busy low
// result    res_valid, res                     out        one-cycle strobe
// config    cfg_valid, cfg_ready, cfg_index,   in / out   valid and ready high
//           cfg_data
//
// Add and query run two mixing steps and six steps on one 32x32 multiplier,
// then per probe a 64-bit remainder retiring 4 bits a cycle and a store read
// and write-back, before the result strobe. A query ends at the first clear
// bit. Clear sweeps the store one word a cycle. After reset a sweep of all
// FILTER_WORDS words runs with busy high. Results cannot be stalled by the
// receiver.
module bloom_filter_double_hash_unit #(
  parameter int FILTER_WORDS = bfdh_pkg::FILTER_WORDS_DEF,
  parameter int MAX_PROBES   = bfdh_pkg::MAX_PROBES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  bfdh_pkg::req_t                    req,
  output logic                              res_valid,
  output bfdh_pkg::res_t                    res,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bfdh_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bfdh_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int AW  = (FILTER_WORDS > 1) ? $clog2(FILTER_WORDS) : 1;
  localparam int NBW = $clog2(FILTER_WORDS * 64 + 1);
  localparam int PW  = $clog2(MAX_PROBES + 1);
  localparam int TopBits = FILTER_WORDS * 64;

  logic [bfdh_pkg::BIT_COUNT_W-1:0]   bit_count;
  logic [bfdh_pkg::PROBE_COUNT_W-1:0] probe_count;
  logic [31:0] nb_wide, np_wide;
  logic [NBW-1:0] nb;
  logic [PW-1:0]  np;
  bfdh_pkg::ctl_t ctl;
  bfdh_pkg::sts_t sts;
  logic [AW-1:0]  clr_addr;

  assign cfg_ready = 1'b1;

  // hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_count   <= bfdh_pkg::BIT_COUNT_RST;
      probe_count <= bfdh_pkg::PROBE_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == bfdh_pkg::REG_BIT_COUNT) begin
        bit_count <= cfg_data[bfdh_pkg::BIT_COUNT_W-1:0];
      end else if (cfg_index == bfdh_pkg::REG_PROBE_COUNT) begin
        probe_count <= cfg_data[bfdh_pkg::PROBE_COUNT_W-1:0];
      end
    end
  end

  // clamp live bit and probe counts
  always_comb begin
    nb_wide = 32'(bit_count);
    if (nb_wide < 32'd64) begin
      nb_wide = 32'd64;
    end
    if (nb_wide > 32'(TopBits)) begin
      nb_wide = 32'(TopBits);
    end
    nb = nb_wide[NBW-1:0];
    np_wide = 32'(probe_count);
    if (np_wide < 32'd1) begin
      np_wide = 32'd1;
    end
    if (np_wide > 32'(MAX_PROBES)) begin
      np_wide = 32'(MAX_PROBES);
    end
    np = np_wide[PW-1:0];
  end

  bfdh_ctrl #(
    .FILTER_WORDS (FILTER_WORDS),
    .MAX_PROBES   (MAX_PROBES),
    .AW           (AW),
    .PW           (PW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .start_cmd (req.cmd),
    .np        (np),
    .sts       (sts),
    .ctl       (ctl),
    .clr_addr  (clr_addr),
    .busy      (busy),
    .res_valid (res_valid)
  );

  bfdh_datapath #(
    .FILTER_WORDS (FILTER_WORDS),
    .AW           (AW),
    .NBW          (NBW)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .clr_addr (clr_addr),
    .req      (req),
    .nb       (nb),
    .sts      (sts),
    .res      (res)
  );

  // one strobe per request
  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    res_valid |=> !res_valid) else $error("result strobe lasted more than a cycle");

  // a strobe only closes a request in flight
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> $past(busy)) else $error("result without a request");

  // an accepted request raises busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("request accepted but not busy");

  // store sweep only while busy
  a_sweep_busy: assert property (@(posedge clk) disable iff (rst)
    ctl.clr_wr |-> busy) else $error("store cleared while idle");

endmodule

### test/tb_bloom_filter_double_hash_unit.sv
module tb_bloom_filter_double_hash_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NWORDS  = bfdh_pkg::FILTER_WORDS_DEF;
  localparam int NPROBES = bfdh_pkg::MAX_PROBES_DEF;
  localparam int RESET_CYCLES = 7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  bfdh_pkg::req_t req = '0;
  logic res_valid;
  bfdh_pkg::res_t res;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [bfdh_pkg::CFG_IDX_W-1:0] cfg_index = bfdh_pkg::REG_BIT_COUNT;
  logic [bfdh_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  bloom_filter_double_hash_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .res_valid(res_valid), .res(res), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [63:0] shadow_words [NWORDS];
  logic [31:0] shadow_count;
  logic [bfdh_pkg::BIT_COUNT_W-1:0] shadow_bits;
  logic [bfdh_pkg::PROBE_COUNT_W-1:0] shadow_probes;

  bfdh_pkg::req_t pending_reqs[$];
  bfdh_pkg::res_t expected_results[$];
  bfdh_pkg::req_t added_keys[$];
  logic no_gap = 1'b0;
  int mismatches = 0;
  int n_add = 0, n_query = 0, n_hit = 0, n_clear = 0, n_none = 0, n_results = 0;

  function automatic logic [63:0] hash_one(bfdh_pkg::req_t r);
    logic [63:0] h;
    h = r.volume_key;
    h = h * 64'd31 + r.file_key_low;
    h = h * 64'd31 + r.file_key_high;
    return h * bfdh_pkg::GOLD_A;
  endfunction

  function automatic logic [63:0] hash_two(bfdh_pkg::req_t r);
    logic [63:0] h;
    h = r.file_key_high;
    h = h * 64'd37 + r.file_key_low;
    h = h * 64'd37 + r.volume_key;
    return h * bfdh_pkg::GOLD_B;
  endfunction

  // Apply one request to the shadow filter and return the result it should give
  function automatic bfdh_pkg::res_t filter_apply(bfdh_pkg::req_t r);
    bfdh_pkg::res_t o;
    logic [63:0] h1, h2, nb, np, pos, w, i;
    logic hit;
    o = '0;
    h1 = hash_one(r);
    h2 = hash_two(r);
    nb = shadow_bits;
    if (nb < 64) nb = 64;
    if (nb > NWORDS * 64) nb = NWORDS * 64;
    np = shadow_probes;
    if (np < 1) np = 1;
    if (np > NPROBES) np = NPROBES;
    case (r.cmd)
      bfdh_pkg::CMD_ADD: begin
        for (i = 0; i < np; i++) begin
          pos = (h1 + i * h2) % nb;
          w = pos >> 6;
          if (w >= NWORDS) w = NWORDS - 1;
          shadow_words[w][pos[5:0]] = 1'b1;
        end
        if (shadow_count != bfdh_pkg::COUNT_MAX) shadow_count++;
        o.maybe_present = 1'b1;
        n_add++;
      end
      bfdh_pkg::CMD_QUERY: begin
        hit = 1'b1;
        for (i = 0; i < np && hit; i++) begin
          pos = (h1 + i * h2) % nb;
          w = pos >> 6;
          if (w >= NWORDS) w = NWORDS - 1;
          if (!shadow_words[w][pos[5:0]]) hit = 1'b0;
        end
        o.maybe_present = hit;
        n_query++;
        if (hit) n_hit++;
      end
      bfdh_pkg::CMD_CLEAR: begin
        foreach (shadow_words[k]) shadow_words[k] = '0;
        shadow_count = '0;
        n_clear++;
      end
      default: n_none++;
    endcase
    o.inserted_count = shadow_count;
    return o;
  endfunction

  // Driver: hold a request until accepted, then fetch the next one
  always @(posedge clk) begin
    logic next_start;
    if (rst) begin
      start <= 1'b0;
    end else begin
      next_start = start;
      if (start && !busy) begin
        expected_results = {expected_results, filter_apply(req)};
        next_start = 1'b0;
      end
      if (!next_start && pending_reqs.size() > 0
          && (no_gap || $urandom_range(99) >= 11)) begin
        req <= pending_reqs.pop_front();
        next_start = 1'b1;
      end
      start <= next_start;
    end
  end

  // Monitor: compare each result strobe against the oldest expectation
  always @(posedge clk) begin
    bfdh_pkg::res_t want;
    if (!rst && res_valid) begin
      n_results++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: present=%0b count=%0d",
                   res.maybe_present, res.inserted_count);
      end else begin
        want = expected_results.pop_front();
        if (res.maybe_present !== want.maybe_present
            || res.inserted_count !== want.inserted_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected present=%0b count=%0d, got present=%0b count=%0d",
                     want.maybe_present, want.inserted_count,
                     res.maybe_present, res.inserted_count);
        end
      end
    end
  end

  function automatic logic [63:0] key_word();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  function automatic bfdh_pkg::req_t fresh_key(bfdh_pkg::cmd_t c);
    bfdh_pkg::req_t r;
    r.cmd = c;
    r.volume_key = key_word();
    r.file_key_low = key_word();
    r.file_key_high = key_word();
    return r;
  endfunction

  task automatic push_req(bfdh_pkg::req_t r);
    pending_reqs = {pending_reqs, r};
    if (r.cmd == bfdh_pkg::CMD_ADD) added_keys = {added_keys, r};
  endtask

  // Random mix: mostly adds and queries of known keys, some misses and noise
  task automatic push_random(int count);
    bfdh_pkg::req_t r;
    int sel;
    repeat (count) begin
      sel = $urandom_range(299);
      if (sel == 0) r = fresh_key(bfdh_pkg::CMD_CLEAR);
      else if (sel < 12) r = fresh_key(bfdh_pkg::CMD_NONE);
      else if (sel < 120) r = fresh_key(bfdh_pkg::CMD_ADD);
      else if (sel < 230 && added_keys.size() > 0) begin
        r = added_keys[$urandom_range(added_keys.size() - 1)];
        r.cmd = bfdh_pkg::CMD_QUERY;
      end else r = fresh_key(bfdh_pkg::CMD_QUERY);
      push_req(r);
    end
  endtask

  // Hold until the sender has drained and every result has arrived
  task automatic drain();
    while (pending_reqs.size() > 0 || start || busy || expected_results.size() > 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [bfdh_pkg::CFG_IDX_W-1:0] idx,
                           logic [bfdh_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == bfdh_pkg::REG_BIT_COUNT) shadow_bits = val[bfdh_pkg::BIT_COUNT_W-1:0];
    else if (idx == bfdh_pkg::REG_PROBE_COUNT)
      shadow_probes = val[bfdh_pkg::PROBE_COUNT_W-1:0];
  endtask

  initial begin
    logic [31:0] bit_set [10];
    logic [31:0] probe_set [10];
    bfdh_pkg::req_t r;
    foreach (shadow_words[k]) shadow_words[k] = '0;
    shadow_count = '0;
    shadow_bits = bfdh_pkg::BIT_COUNT_RST;
    shadow_probes = bfdh_pkg::PROBE_COUNT_RST;
    bit_set = '{1048576, 64, 64, 0, 100, 32'h001F_FFFF, 4096, 1000, 1048576, 640};
    probe_set = '{7, 1, 20, 0, 31, 3, 20, 5, 20, 2};
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed: extreme keys, every command, clear, then add and query
    r = '{bfdh_pkg::CMD_ADD, '0, '0, '0};
    push_req(r);
    r = '{bfdh_pkg::CMD_ADD, '1, '1, '1};
    push_req(r);
    r = '{bfdh_pkg::CMD_QUERY, '0, '0, '0};
    push_req(r);
    r = '{bfdh_pkg::CMD_QUERY, '1, '1, '1};
    push_req(r);
    r = '{bfdh_pkg::CMD_QUERY, 64'h1, '0, '1};
    push_req(r);
    push_req(fresh_key(bfdh_pkg::CMD_NONE));
    push_req(fresh_key(bfdh_pkg::CMD_ADD));
    push_req(fresh_key(bfdh_pkg::CMD_QUERY));
    r = '{bfdh_pkg::CMD_CLEAR, '1, '1, '1};
    push_req(r);
    r = '{bfdh_pkg::CMD_QUERY, '1, '1, '1};
    push_req(r);
    r = '{bfdh_pkg::CMD_ADD, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, '1};
    push_req(r);
    r.cmd = bfdh_pkg::CMD_QUERY;
    push_req(r);
    drain();

    // phases over register settings, sender paused between them
    for (int p = 0; p < 10; p++) begin
      write_reg(bfdh_pkg::REG_BIT_COUNT, bit_set[p]);
      write_reg(bfdh_pkg::REG_PROBE_COUNT, probe_set[p]);
      no_gap = (p == 3);
      push_random(175);
      drain();
    end

    $display("covered %0d adds, %0d queries (%0d maybe present), %0d clears, %0d unused codes",
             n_add, n_query, n_hit, n_clear, n_none);
    $display("10 register settings from minimum to beyond maximum, %0d results checked",
             n_results);
    repeat (50) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("[bloom_filter_double_hash_unit] OK");
    end else begin
      $display("mismatches: %0d, results outstanding: %0d", mismatches, expected_results.size());
      $display("[bloom_filter_double_hash_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #1s;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("[bloom_filter_double_hash_unit] ERROR");
    $finish;
  end

endmodule

### sim.f
src/bfdh_pkg.sv
src/bfdh_ram.sv
src/bfdh_datapath.sv
src/bfdh_ctrl.sv
src/bloom_filter_double_hash_unit.sv
test/tb_bloom_filter_double_hash_unit.sv
